/* rtl/mcs_pkg.sv */
// ----------------------------------------------------------------------------
// mcs_pkg
// Types, phase codes and per-phase constants of the commissioning sequencer.
// ----------------------------------------------------------------------------
package mcs_pkg;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_TICK   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_ABORT  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RES      = 4'd1,
		PH_IND      = 4'd2,
		PH_KV       = 4'd3,
		PH_POLES    = 4'd4,
		PH_TIMING   = 4'd5,
		PH_VALIDATE = 4'd6,
		PH_COMMIT   = 4'd7,
		PH_COMPLETE = 4'd8,
		PH_ERROR    = 4'd9
	} phase_t;

	localparam int TGT_W  = 8;
	localparam int SMP_W  = 16;
	localparam int TMO_W  = 16;
	localparam int RNG_W  = 5;
	localparam int PCT_W  = 7;
	localparam int PROD_W = SMP_W + RNG_W;

	typedef struct packed {
		op_t         op;
		logic [31:0] time_ms;
		logic        motor_idle;
		logic [7:0]  confidence;
	} cmd_t;

	function automatic logic [TMO_W-1:0] ph_timeout(input phase_t ph);
		logic [TMO_W-1:0] t;
		unique case (ph)
			PH_RES, PH_IND:                 t = TMO_W'(2000);
			PH_KV, PH_POLES, PH_TIMING:     t = TMO_W'(5000);
			PH_VALIDATE:                    t = TMO_W'(3000);
			PH_COMMIT:                      t = TMO_W'(1000);
			default:                        t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [TGT_W-1:0] ph_target(input phase_t ph);
		logic [TGT_W-1:0] t;
		unique case (ph)
			PH_RES, PH_POLES, PH_VALIDATE:  t = TGT_W'(100);
			PH_IND:                         t = TGT_W'(50);
			PH_KV, PH_TIMING:               t = TGT_W'(200);
			default:                        t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [PCT_W-1:0] base_pct(input phase_t ph);
		logic [PCT_W-1:0] p;
		unique case (ph)
			PH_RES:         p = PCT_W'(10);
			PH_IND:         p = PCT_W'(20);
			PH_KV:          p = PCT_W'(40);
			PH_POLES:       p = PCT_W'(55);
			PH_TIMING:      p = PCT_W'(70);
			PH_VALIDATE:    p = PCT_W'(85);
			PH_COMMIT:      p = PCT_W'(95);
			PH_COMPLETE:    p = PCT_W'(100);
			default:        p = '0;
		endcase
		return p;
	endfunction

	// span from this phase's base to the next one's (zero from complete on)
	function automatic logic [RNG_W-1:0] range_pct(input phase_t ph);
		logic [RNG_W-1:0] r;
		unique case (ph)
			PH_IDLE, PH_RES:    r = RNG_W'(10);
			PH_IND:             r = RNG_W'(20);
			PH_KV, PH_POLES:    r = RNG_W'(15);
			PH_TIMING:          r = RNG_W'(15);
			PH_VALIDATE:        r = RNG_W'(10);
			PH_COMMIT:          r = RNG_W'(5);
			default:            r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/mcs_ifs.sv */
// ----------------------------------------------------------------------------
// mcs_ifs
// Valid/ready channels of the commissioning sequencer.
// ----------------------------------------------------------------------------
interface mcs_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] time_ms;
	logic        motor_idle;
	logic [7:0]  confidence;

	modport source (output valid, opcode, time_ms, motor_idle, confidence, input ready);
	modport sink   (input valid, opcode, time_ms, motor_idle, confidence, output ready);
endinterface

interface mcs_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] phase;
	logic       busy_res;
	logic [6:0] progress_pct;
	logic       drive_off;
	logic       validation_ok;

	modport source (output valid, phase, busy_res, progress_pct, drive_off, validation_ok,
		input ready);
	modport sink   (input valid, phase, busy_res, progress_pct, drive_off, validation_ok,
		output ready);
endinterface

interface mcs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] min_confidence;

	modport source (output valid, min_confidence, input ready);
	modport sink   (input valid, min_confidence, output ready);
endinterface

/* rtl/mcs_front.sv */
// ----------------------------------------------------------------------------
// mcs_front
// Accepts command transfers, decodes the opcode and queues them (two deep).
// ----------------------------------------------------------------------------
module mcs_front
	import mcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mcs_cmd_if.sink     cmd,
	output logic        q_valid,
	output cmd_t        q_cmd,
	input  logic        q_pop
);

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       dec;

	always_comb begin
		dec.op         = op_t'(cmd.opcode);
		dec.time_ms    = cmd.time_ms;
		dec.motor_idle = cmd.motor_idle;
		dec.confidence = cmd.confidence;
	end

	assign cmd.ready = (cnt_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_cmd     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= dec;
		end
	end

endmodule

/* rtl/mcs_div.sv */
// ----------------------------------------------------------------------------
// mcs_div
// Restoring divider, one quotient bit per cycle, for progress interpolation.
// ----------------------------------------------------------------------------
module mcs_div
	import mcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [TGT_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam int CW = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] dq_q;
	logic [TGT_W-1:0]  rem_q;
	logic [TGT_W-1:0]  dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TGT_W:0]    rem_sh;
	logic              ge;
	logic [TGT_W:0]    rem_sub;

	assign rem_sh  = {rem_q, dq_q[PROD_W-1]};
	assign ge      = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dq_q   <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dq_q   <= dividend;
				dvs_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= CW'(PROD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? rem_sub[TGT_W-1:0] : rem_sh[TGT_W-1:0];
				dq_q  <= {dq_q[PROD_W-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

/* rtl/mcs_back.sv */
// ----------------------------------------------------------------------------
// mcs_back
// Executes queued commands on the phase state, computes progress, and holds
// the result register.
// ----------------------------------------------------------------------------
module mcs_back
	import mcs_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	input  logic [7:0]  min_conf,
	mcs_rsp_if.source   rsp
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_OUT
	} bstate_t;

	bstate_t              st_q;
	bstate_t              st_n;

	phase_t               ph_q;
	logic [TIME_BITS-1:0] entry_q;
	logic [TMO_W-1:0]     tmo_q;
	logic [TGT_W-1:0]     tgt_q;
	logic [SMP_W-1:0]     smp_q;
	logic                 pass_q;
	logic                 busy_q;
	logic                 off_q;
	logic [PCT_W-1:0]     pct_q;

	logic                 out_vld_q;
	phase_t               out_ph_q;
	logic                 out_busy_q;
	logic [PCT_W-1:0]     out_pct_q;
	logic                 out_off_q;
	logic                 out_ok_q;

	phase_t               ph_n;
	phase_t               enter_ph;
	logic                 enter;
	logic [TIME_BITS-1:0] entry_n;
	logic [TMO_W-1:0]     tmo_n;
	logic [TGT_W-1:0]     tgt_n;
	logic [SMP_W-1:0]     smp_n;
	logic                 pass_n;
	logic                 busy_n;
	logic                 off_n;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic                 timed_out;
	logic [SMP_W-1:0]     smp_inc;
	logic                 tgt_hit;

	logic [RNG_W-1:0]     rng;
	logic [PROD_W-1:0]    prod;
	logic                 need_div;
	logic                 div_start;
	logic                 div_done;
	logic [PROD_W-1:0]    div_q;
	logic [PCT_W-1:0]     interp;
	logic                 out_load;

	assign now_t     = TIME_BITS'(q_cmd.time_ms);
	assign elapsed   = now_t - entry_q;
	assign timed_out = (ph_q > PH_IDLE) && (ph_q < PH_COMPLETE)
		&& (elapsed > TIME_BITS'(tmo_q))
		&& (smp_q < SMP_W'(tgt_q >> 1));
	assign smp_inc   = smp_q + SMP_W'(1);
	assign tgt_hit   = (smp_q >= SMP_W'(tgt_q));

	always_comb begin
		ph_n     = ph_q;
		entry_n  = entry_q;
		tmo_n    = tmo_q;
		tgt_n    = tgt_q;
		smp_n    = smp_q;
		pass_n   = pass_q;
		busy_n   = 1'b0;
		off_n    = 1'b0;
		enter    = 1'b0;
		enter_ph = ph_q;
		unique case (q_cmd.op)
			OP_START: begin
				if (q_cmd.motor_idle && (ph_q == PH_IDLE || ph_q == PH_COMPLETE
						|| ph_q == PH_ERROR)) begin
					pass_n   = 1'b0;
					enter    = 1'b1;
					enter_ph = PH_RES;
					busy_n   = 1'b1;
				end
			end
			OP_TICK: begin
				if (timed_out) begin
					ph_n  = PH_ERROR;
					off_n = 1'b1;
				end else begin
					unique case (ph_q)
						PH_RES, PH_IND: begin
							busy_n = 1'b1;
							if (smp_inc >= SMP_W'(tgt_q)) begin
								enter    = 1'b1;
								enter_ph = (ph_q == PH_RES) ? PH_IND : PH_KV;
							end else begin
								smp_n = smp_inc;
							end
						end
						PH_KV, PH_POLES, PH_TIMING: begin
							busy_n = 1'b1;
							if (tgt_hit) begin
								enter = 1'b1;
								unique case (ph_q)
									PH_KV:    enter_ph = PH_POLES;
									PH_POLES: enter_ph = PH_TIMING;
									default:  enter_ph = PH_VALIDATE;
								endcase
							end
						end
						PH_VALIDATE: begin
							busy_n = 1'b1;
							if (tgt_hit) begin
								pass_n = (q_cmd.confidence >= min_conf);
								if (q_cmd.confidence >= min_conf) begin
									enter    = 1'b1;
									enter_ph = PH_COMMIT;
								end else begin
									ph_n   = PH_ERROR;
									off_n  = 1'b1;
									busy_n = 1'b0;
								end
							end
						end
						PH_COMMIT: begin
							ph_n  = PH_COMPLETE;
							off_n = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			OP_SAMPLE: begin
				if (ph_q >= PH_KV && ph_q <= PH_VALIDATE && smp_q != '1) begin
					smp_n = smp_inc;
				end
			end
			OP_ABORT: begin
				ph_n  = PH_IDLE;
				off_n = 1'b1;
			end
			default: begin
			end
		endcase
		if (enter) begin
			ph_n    = enter_ph;
			entry_n = now_t;
			tmo_n   = ph_timeout(enter_ph);
			tgt_n   = ph_target(enter_ph);
			smp_n   = '0;
		end
	end

	assign rng       = range_pct(ph_q);
	assign prod      = PROD_W'(smp_q) * PROD_W'(rng);
	assign need_div  = (ph_q < PH_ERROR) && (tgt_q != '0);
	assign div_start = (st_q == B_MUL) && need_div;
	assign interp    = (div_q > PROD_W'(rng)) ? PCT_W'(rng) : PCT_W'(div_q);
	assign out_load  = (st_q == B_OUT) && (!out_vld_q || rsp.ready);
	assign q_pop     = (st_q == B_IDLE) && q_valid;

	mcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (tgt_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			B_IDLE:  if (q_valid) st_n = B_MUL;
			B_MUL:   st_n = need_div ? B_DIV : B_OUT;
			B_DIV:   if (div_done) st_n = B_OUT;
			B_OUT:   if (out_load) st_n = B_IDLE;
			default: st_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			ph_q       <= PH_IDLE;
			entry_q    <= '0;
			tmo_q      <= '0;
			tgt_q      <= '0;
			smp_q      <= '0;
			pass_q     <= 1'b0;
			busy_q     <= 1'b0;
			off_q      <= 1'b0;
			pct_q      <= '0;
			out_vld_q  <= 1'b0;
			out_ph_q   <= PH_IDLE;
			out_busy_q <= 1'b0;
			out_pct_q  <= '0;
			out_off_q  <= 1'b0;
			out_ok_q   <= 1'b0;
		end else begin
			st_q <= st_n;
			if (q_pop) begin
				ph_q    <= ph_n;
				entry_q <= entry_n;
				tmo_q   <= tmo_n;
				tgt_q   <= tgt_n;
				smp_q   <= smp_n;
				pass_q  <= pass_n;
				busy_q  <= busy_n;
				off_q   <= off_n;
			end
			if (st_q == B_MUL) begin
				pct_q <= (ph_q >= PH_ERROR) ? '0 : base_pct(ph_q);
			end
			if (st_q == B_DIV && div_done) begin
				pct_q <= pct_q + interp;
			end
			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_ph_q   <= ph_q;
				out_busy_q <= busy_q;
				out_pct_q  <= pct_q;
				out_off_q  <= off_q;
				out_ok_q   <= pass_q;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.phase         = out_ph_q;
	assign rsp.busy_res      = out_busy_q;
	assign rsp.progress_pct  = out_pct_q;
	assign rsp.drive_off     = out_off_q;
	assign rsp.validation_ok = out_ok_q;

endmodule

/* rtl/motor_commissioning_sequencer_top.sv */
// ----------------------------------------------------------------------------
// motor_commissioning_sequencer_top
// Commissioning phase sequencer with progress reporting.
// ----------------------------------------------------------------------------
// Each command transfer yields exactly one response transfer. After leaving
// the two-deep input queue, a command passes through the phase state update,
// the progress multiply, the bit-serial progress divide, the end of the
// interpolation and the response register; the divide is skipped in error
// or with a zero sample target. Commands keep queueing while a response
// waits. min_confidence is to be written over cfg only while the block is
// idle; the block itself does not enforce this. It resets to 200.
// TIME_BITS sets the width of the wrapping phase timer.
// ----------------------------------------------------------------------------
module motor_commissioning_sequencer_top
	import mcs_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mcs_cmd_if.sink    cmd,
	mcs_rsp_if.source  rsp,
	mcs_cfg_if.sink    cfg
);

	logic       q_valid;
	cmd_t       q_cmd;
	logic       q_pop;
	logic [7:0] min_conf_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q <= 8'd200;
		end else if (cfg.valid && cfg.ready) begin
			min_conf_q <= cfg.min_confidence;
		end
	end

	mcs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	mcs_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.min_conf (min_conf_q),
		.rsp      (rsp)
	);

	a_off_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.drive_off |-> (rsp.phase == PH_IDLE
			|| rsp.phase == PH_COMPLETE || rsp.phase == PH_ERROR))
		else $error("drive off reported outside idle, complete or error");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.progress_pct <= 7'd100)
			&& (rsp.phase != PH_ERROR || rsp.progress_pct == 7'd0))
		else $error("progress out of range");

	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.phase == PH_COMMIT || rsp.phase == PH_COMPLETE)
			&& !rsp.drive_off |-> rsp.validation_ok)
		else $error("commit phase without passed validation");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

endmodule

/* tb/tb_motor_commissioning_sequencer_top.sv */
// ----------------------------------------------------------------------------
// tb_motor_commissioning_sequencer_top
// Self-checking bench for the commissioning sequencer. A short directed table
// covers refused starts, ignored items, timeouts on wrapping time and aborts.
// Random traffic follows: a complete commissioning run that ends in a passing
// or a failing validation, and partial runs broken by abort, timeout or noise.
// Each response is checked against the table or an in-bench phase model, with
// random idle bursts on the command and response channels.
// ----------------------------------------------------------------------------
module tb_motor_commissioning_sequencer_top;
	import mcs_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		phase_t     phase;
		logic       busy;
		logic [6:0] pct;
		logic       off;
		logic       ok;
	} status_t;

	typedef struct {
		op_t         op;
		logic [31:0] t;
		logic        idle;
		logic [7:0]  conf;
		bit          typed;
		status_t     want;
	} step_row_t;

	logic clk;
	logic arst_n;

	mcs_cmd_if cmd_if();
	mcs_rsp_if rsp_if();
	mcs_cfg_if cfg_if();

	motor_commissioning_sequencer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// model state
	phase_t      m_phase;
	logic [31:0] m_entry;
	logic [15:0] m_tmo;
	logic [7:0]  m_tgt;
	logic [15:0] m_smp;
	logic        m_pass;
	logic [7:0]  m_min_conf;

	status_t     status_q[$];
	status_t     want;
	step_row_t   plan[$];
	logic [31:0] t_now;
	bit          gaps_on;
	bit          stalls_on;
	int          n_err;
	int          n_sent;
	int          quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int phase_floor(input int p);
		case (p)
			1: return 10;
			2: return 20;
			3: return 40;
			4: return 55;
			5: return 70;
			6: return 85;
			7: return 95;
			8: return 100;
			default: return 0;
		endcase
	endfunction

	function automatic logic [6:0] progress_now();
		int p, lo, hi, span, q;
		p = int'(m_phase);
		if (p >= int'(PH_ERROR))
			return 7'd0;
		lo = phase_floor(p);
		hi = (p + 1 < int'(PH_ERROR)) ? phase_floor(p + 1) : 100;
		if (m_tgt == 8'd0)
			return 7'(lo);
		span = hi - lo;
		q = int'(m_smp) * span / int'(m_tgt);
		if (q > span)
			q = span;
		return 7'(lo + q);
	endfunction

	function automatic void go_phase(input phase_t ph, input logic [31:0] now,
		input logic [15:0] tmo, input logic [7:0] tgt);
		m_phase = ph;
		m_entry = now;
		m_tmo   = tmo;
		m_tgt   = tgt;
		m_smp   = 16'd0;
	endfunction

	function automatic void seq_reset();
		m_min_conf = 8'd200;
		m_phase    = PH_IDLE;
		m_entry    = 32'd0;
		m_tmo      = 16'd0;
		m_tgt      = 8'd0;
		m_smp      = 16'd0;
		m_pass     = 1'b0;
	endfunction

	function automatic void run_tick(input logic [31:0] now, input logic [7:0] conf,
		output logic busy, output logic off);
		logic [31:0] el;
		busy = 1'b0;
		off  = 1'b0;
		if (m_phase > PH_IDLE && m_phase < PH_COMPLETE) begin
			el = now - m_entry;
			if (el > 32'(m_tmo) && m_smp < 16'(m_tgt >> 1)) begin
				m_phase = PH_ERROR;
				off = 1'b1;
				return;
			end
		end
		busy = 1'b1;
		case (m_phase)
			PH_RES: begin
				m_smp++;
				if (m_smp >= 16'(m_tgt))
					go_phase(PH_IND, now, 16'd2000, 8'd50);
			end
			PH_IND: begin
				m_smp++;
				if (m_smp >= 16'(m_tgt))
					go_phase(PH_KV, now, 16'd5000, 8'd200);
			end
			PH_KV: if (m_smp >= 16'(m_tgt)) go_phase(PH_POLES, now, 16'd5000, 8'd100);
			PH_POLES: if (m_smp >= 16'(m_tgt)) go_phase(PH_TIMING, now, 16'd5000, 8'd200);
			PH_TIMING: if (m_smp >= 16'(m_tgt)) go_phase(PH_VALIDATE, now, 16'd3000, 8'd100);
			PH_VALIDATE: begin
				if (m_smp >= 16'(m_tgt)) begin
					m_pass = (conf >= m_min_conf);
					if (m_pass) begin
						go_phase(PH_COMMIT, now, 16'd1000, 8'd0);
					end else begin
						m_phase = PH_ERROR;
						off  = 1'b1;
						busy = 1'b0;
					end
				end
			end
			PH_COMMIT: begin
				m_phase = PH_COMPLETE;
				off  = 1'b1;
				busy = 1'b0;
			end
			default: busy = 1'b0;
		endcase
	endfunction

	// advances the model by one command and returns the expected response
	function automatic status_t commission_step(input cmd_t c);
		status_t     s;
		logic        busy, off;
		busy = 1'b0;
		off  = 1'b0;
		case (c.op)
			OP_START: begin
				if (c.motor_idle && (m_phase == PH_IDLE || m_phase == PH_COMPLETE ||
					m_phase == PH_ERROR)) begin
					m_pass = 1'b0;
					go_phase(PH_RES, c.time_ms, 16'd2000, 8'd100);
					busy = 1'b1;
				end
			end
			OP_TICK: run_tick(c.time_ms, c.confidence, busy, off);
			OP_SAMPLE: begin
				if (m_phase >= PH_KV && m_phase <= PH_VALIDATE && m_smp != 16'hFFFF)
					m_smp++;
			end
			default: begin
				m_phase = PH_IDLE;
				off = 1'b1;
			end
		endcase
		s.phase = m_phase;
		s.busy  = busy;
		s.pct   = progress_now();
		s.off   = off;
		s.ok    = m_pass;
		return s;
	endfunction

	function automatic void add_row(input op_t op, input logic [31:0] t, input logic idle,
		input logic [7:0] conf, input bit typed, input phase_t ph, input logic busy,
		input logic [6:0] pct, input logic off, input logic ok);
		step_row_t r;
		r.op         = op;
		r.t          = t;
		r.idle       = idle;
		r.conf       = conf;
		r.typed      = typed;
		r.want.phase = ph;
		r.want.busy  = busy;
		r.want.pct   = pct;
		r.want.off   = off;
		r.want.ok    = ok;
		plan.push_back(r);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			n_err++;
		end
	endfunction

	task automatic push_cmd(input op_t op, input logic [31:0] t, input logic idle,
		input logic [7:0] conf);
		cmd_t c;
		c.op         = op;
		c.time_ms    = t;
		c.motor_idle = idle;
		c.confidence = conf;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.opcode     <= op;
		cmd_if.time_ms    <= t;
		cmd_if.motor_idle <= idle;
		cmd_if.confidence <= conf;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		status_q.push_back(commission_step(c));
		n_sent++;
	endtask

	task automatic drain();
		cmd_if.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_min_conf(input logic [7:0] v);
		drain();
		cfg_if.valid          <= 1'b1;
		cfg_if.min_confidence <= v;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		m_min_conf = v;
	endtask

	// one item that keeps the current phase moving toward its target
	task automatic well_formed(input logic [7:0] vconf);
		logic [7:0] c;
		c = (m_phase == PH_VALIDATE) ? vconf : 8'($urandom);
		if (m_phase >= PH_KV && m_phase <= PH_VALIDATE && $urandom_range(0, 9) != 0) begin
			push_cmd(OP_SAMPLE, t_now, 1'($urandom_range(0, 1)), c);
		end else begin
			t_now += 32'($urandom_range(0, 12));
			push_cmd(OP_TICK, t_now, 1'($urandom_range(0, 1)), c);
		end
	endtask

	task automatic full_run(input logic [7:0] final_conf);
		if (m_phase >= PH_RES && m_phase <= PH_COMMIT)
			push_cmd(OP_ABORT, t_now, 1'b1, 8'($urandom));
		t_now = $urandom;
		push_cmd(OP_START, t_now, 1'b1, 8'($urandom));
		while (m_phase >= PH_RES && m_phase <= PH_COMMIT) begin
			if ($urandom_range(0, 39) == 0)
				push_cmd(OP_START, t_now, 1'($urandom_range(0, 1)), 8'($urandom));
			well_formed(final_conf);
		end
	endtask

	task automatic broken_run();
		logic [31:0] d;
		t_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 3000))
			: 32'($urandom);
		push_cmd(OP_START, t_now, 1'($urandom_range(0, 5) != 0), 8'($urandom));
		repeat ($urandom_range(0, 40)) begin
			if (m_phase >= PH_RES && m_phase <= PH_COMMIT)
				well_formed(8'($urandom));
		end
		case ($urandom_range(0, 3))
			0: push_cmd(OP_ABORT, t_now, 1'($urandom_range(0, 1)), 8'($urandom));
			1: begin
				// land on the timeout edge, just past it, or at a random time
				d = 32'(m_tmo) + 32'($urandom_range(0, 1));
				if ($urandom_range(0, 2) == 0)
					d = $urandom;
				t_now = m_entry + d;
				push_cmd(OP_TICK, t_now, 1'($urandom_range(0, 1)), 8'($urandom));
			end
			2: begin
				repeat ($urandom_range(1, 12))
					push_cmd(op_t'($urandom_range(0, 3)), 32'($urandom),
						1'($urandom_range(0, 1)), 8'($urandom));
			end
			default: push_cmd(OP_START, t_now, 1'($urandom_range(0, 1)), 8'($urandom));
		endcase
	endtask

	always @(posedge clk) begin
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (status_q.size() == 0) begin
				$error("response transfer with no command pending, phase %0d", rsp_if.phase);
				n_err++;
			end else begin
				want = status_q.pop_front();
				check_field("phase", 32'(want.phase), 32'(rsp_if.phase));
				check_field("busy_res", 32'(want.busy), 32'(rsp_if.busy_res));
				check_field("progress_pct", 32'(want.pct), 32'(rsp_if.progress_pct));
				check_field("drive_off", 32'(want.off), 32'(rsp_if.drive_off));
				check_field("validation_ok", 32'(want.ok), 32'(rsp_if.validation_ok));
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stalls_on && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
		end
	end

	initial begin
		step_row_t  r;
		arst_n                = 1'b0;
		cmd_if.valid          = 1'b0;
		cmd_if.opcode         = OP_START;
		cmd_if.time_ms        = 32'd0;
		cmd_if.motor_idle     = 1'b0;
		cmd_if.confidence     = 8'd0;
		cfg_if.valid          = 1'b0;
		cfg_if.min_confidence = 8'd0;
		n_err     = 0;
		n_sent    = 0;
		quiet     = 0;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		t_now     = 32'd0;
		seq_reset();

		add_row(OP_TICK,   32'h0000_0000, 1'b1, 8'h00, 1'b1, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b1, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_START,  32'h0000_0000, 1'b0, 8'h00, 1'b1, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_ABORT,  32'h0000_0000, 1'b1, 8'h00, 1'b1, PH_IDLE,  1'b0, 7'd0,  1'b1, 1'b0);
		add_row(OP_START,  32'hFFFF_FF00, 1'b1, 8'hFF, 1'b1, PH_RES,   1'b1, 7'd10, 1'b0, 1'b0);
		add_row(OP_START,  32'h0000_0000, 1'b1, 8'h00, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_SAMPLE, 32'h0000_0000, 1'b1, 8'h55, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_TICK,   32'h0000_0000, 1'b1, 8'hAA, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		// wrapped elapsed time exactly at the limit, then one past it
		add_row(OP_TICK,   32'h0000_06D0, 1'b0, 8'h00, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_TICK,   32'h0000_06D1, 1'b1, 8'h00, 1'b1, PH_ERROR, 1'b0, 7'd0,  1'b1, 1'b0);
		add_row(OP_TICK,   32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, PH_ERROR, 1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_SAMPLE, 32'h0000_0000, 1'b1, 8'h00, 1'b1, PH_ERROR, 1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_START,  32'h1234_5678, 1'b0, 8'h00, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_START,  32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1, PH_RES,   1'b1, 7'd10, 1'b0, 1'b0);
		add_row(OP_TICK,   32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_TICK,   32'hFFFF_FFFE, 1'b1, 8'h00, 1'b1, PH_ERROR, 1'b0, 7'd0,  1'b1, 1'b0);
		add_row(OP_ABORT,  32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_ABORT,  32'h0000_0000, 1'b0, 8'h00, 1'b1, PH_IDLE,  1'b0, 7'd0,  1'b1, 1'b0);
		add_row(OP_START,  32'h0000_0064, 1'b1, 8'h3C, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_TICK,   32'h0000_00C8, 1'b1, 8'hC3, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_TICK,   32'h0000_012C, 1'b0, 8'h0F, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_ABORT,  32'h0000_012C, 1'b1, 8'hF0, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);
		add_row(OP_TICK,   32'h0000_0190, 1'b1, 8'h00, 1'b0, PH_IDLE,  1'b0, 7'd0,  1'b0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			r = plan[i];
			push_cmd(r.op, r.t, r.idle, r.conf);
			if (r.typed)
				status_q[status_q.size() - 1] = r.want;
		end

		// threshold at full scale: validation passes only at full confidence
		set_min_conf(8'd255);
		gaps_on   = 1'($urandom_range(0, 1));
		stalls_on = 1'($urandom_range(0, 1));
		full_run(($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(0, 254)));

		set_min_conf(8'd0);
		while (n_sent < 950) begin
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			broken_run();
		end

		set_min_conf(8'($urandom));
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		repeat (3) broken_run();

		drain();
		repeat (40) @(posedge clk);
		if (n_err == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
